/* rtl/core/fnp_pkg.sv */
// Shared types and character constants for the FASTA nucleotide packer.
package fnp_pkg;

    localparam int unsigned CHAR_W  = 8;
    localparam int unsigned CODE_W  = 2;
    localparam int unsigned SLOTS   = 4;
    localparam int unsigned COUNT_W = 2;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 2;

    // Character codes (ASCII).
    localparam logic [CHAR_W-1:0] CHR_NEWLINE = 8'h0A;
    localparam logic [CHAR_W-1:0] CHR_SEMI    = 8'h3B;
    localparam logic [CHAR_W-1:0] CHR_GT      = 8'h3E;
    localparam logic [CHAR_W-1:0] CHR_A       = 8'h41;
    localparam logic [CHAR_W-1:0] CHR_C       = 8'h43;
    localparam logic [CHAR_W-1:0] CHR_G       = 8'h47;
    localparam logic [CHAR_W-1:0] CHR_T       = 8'h54;
    localparam logic [CHAR_W-1:0] CHR_LOW_A   = 8'h61;
    localparam logic [CHAR_W-1:0] CHR_LOW_Z   = 8'h7A;
    localparam logic [CHAR_W-1:0] CASE_OFFSET = 8'h20;

    // Nucleotide A always packs as zero.
    localparam logic [CODE_W-1:0] CODE_A = 2'd0;

    // Input action codes.
    localparam logic ACT_CHAR = 1'b0;
    localparam logic ACT_END  = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_DROP_PARTIAL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CODE_C       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CODE_G       = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CODE_T       = 2'd3;

    typedef struct packed {
        logic [CODE_W-1:0] code_c;
        logic [CODE_W-1:0] code_g;
        logic [CODE_W-1:0] code_t;
    } t_codes;

    typedef struct packed {
        logic              is_letter;
        logic              is_hdr_start;
        logic              is_newline;
        logic [CODE_W-1:0] code;
    } t_char_class;

    typedef struct packed {
        logic [CHAR_W-1:0]  packed_byte;
        logic               byte_valid;
        logic [COUNT_W-1:0] empty_slots;
        logic               stream_done;
    } t_result;

endpackage

/* rtl/core/fnp_classify.sv */
// Character classifier: case folding, header markers and nucleotide codes.
module fnp_classify (
    input  logic [fnp_pkg::CHAR_W-1:0] i_char,
    input  fnp_pkg::t_codes            i_codes,
    output fnp_pkg::t_char_class       o_class
);
    import fnp_pkg::*;

    logic [CHAR_W-1:0] folded;

    always_comb begin
        folded = i_char;
        if (i_char inside {[CHR_LOW_A:CHR_LOW_Z]}) begin
            folded = i_char - CASE_OFFSET;
        end
    end

    always_comb begin
        o_class            = '0;
        o_class.is_newline = (i_char == CHR_NEWLINE);
        case (folded)
            CHR_A: begin
                o_class.is_letter = 1'b1;
                o_class.code      = CODE_A;
            end
            CHR_C: begin
                o_class.is_letter = 1'b1;
                o_class.code      = i_codes.code_c;
            end
            CHR_G: begin
                o_class.is_letter = 1'b1;
                o_class.code      = i_codes.code_g;
            end
            CHR_T: begin
                o_class.is_letter = 1'b1;
                o_class.code      = i_codes.code_t;
            end
            CHR_SEMI, CHR_GT: begin
                o_class.is_hdr_start = 1'b1;
            end
            default: begin
                o_class.is_letter = 1'b0;
            end
        endcase
    end

endmodule

/* rtl/core/fnp_pack.sv */
// Packing state, flush logic and two-entry output register.
module fnp_pack (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_accept,
    input  logic                       i_action,
    input  fnp_pkg::t_char_class       i_class,
    input  logic                       i_drop_partial,
    output logic                       o_full,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output fnp_pkg::t_result           o_out
);
    import fnp_pkg::*;

    logic [CHAR_W-1:0]  r_acc, n_acc;
    logic [COUNT_W-1:0] r_held, n_held;
    logic               r_in_header, n_in_header;
    t_result            r_out, n_out;
    logic               r_out_valid, n_out_valid;
    t_result            r_skid, n_skid;
    logic               r_skid_valid, n_skid_valid;

    t_result           res;
    logic              res_valid;
    logic [CHAR_W-1:0] acc_shift;
    logic [CHAR_W-1:0] flush_byte;
    logic              pop;

    assign acc_shift = {r_acc[CHAR_W-CODE_W-1:0], i_class.code};

    always_comb begin
        case (r_held)
            2'd1:    flush_byte = {r_acc[1:0], 6'b0};
            2'd2:    flush_byte = {r_acc[3:0], 4'b0};
            2'd3:    flush_byte = {r_acc[5:0], 2'b0};
            default: flush_byte = '0;
        endcase
    end

    // Next packing state and the result of the accepted word.
    always_comb begin
        n_acc       = r_acc;
        n_held      = r_held;
        n_in_header = r_in_header;
        res         = '0;
        res_valid   = 1'b0;
        if (i_accept) begin
            if (i_action == ACT_END) begin
                res_valid       = 1'b1;
                res.stream_done = 1'b1;
                if (r_held != '0 && !i_drop_partial) begin
                    res.packed_byte = flush_byte;
                    res.byte_valid  = 1'b1;
                    res.empty_slots = COUNT_W'(3'(SLOTS) - {1'b0, r_held});
                end
                n_acc       = '0;
                n_held      = '0;
                n_in_header = 1'b0;
            end else if (r_in_header) begin
                if (i_class.is_newline) begin
                    n_in_header = 1'b0;
                end
            end else if (i_class.is_letter) begin
                if (r_held == COUNT_W'(SLOTS - 1)) begin
                    res_valid       = 1'b1;
                    res.packed_byte = acc_shift;
                    res.byte_valid  = 1'b1;
                    n_acc           = '0;
                    n_held          = '0;
                end else begin
                    n_acc  = acc_shift;
                    n_held = r_held + 1'b1;
                end
            end else if (i_class.is_hdr_start) begin
                n_in_header = 1'b1;
            end
        end
    end

    // Output register backed by a skid entry; input stalls only while the skid is full.
    assign pop = r_out_valid && !i_out_stall;

    always_comb begin
        n_out        = r_out;
        n_out_valid  = r_out_valid;
        n_skid       = r_skid;
        n_skid_valid = r_skid_valid;
        if (pop) begin
            if (r_skid_valid) begin
                n_out        = r_skid;
                n_out_valid  = 1'b1;
                n_skid_valid = 1'b0;
            end else begin
                n_out       = res;
                n_out_valid = res_valid;
            end
        end else if (!r_out_valid) begin
            n_out       = res;
            n_out_valid = res_valid;
        end else if (res_valid) begin
            n_skid       = res;
            n_skid_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc        <= '0;
            r_held       <= '0;
            r_in_header  <= 1'b0;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_acc        <= n_acc;
            r_held       <= n_held;
            r_in_header  <= n_in_header;
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_full      = r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry holds a word while the output register is empty");

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_action == ACT_END) |=> (r_held == '0 && r_acc == '0 && !r_in_header))
        else $error("packing state not cleared after end of stream");

    a_flush_slots: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.stream_done && r_out.byte_valid) |-> (r_out.empty_slots != '0))
        else $error("flushed partial byte reports no empty slots");

    a_full_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.stream_done) |-> (r_out.byte_valid && r_out.empty_slots == '0))
        else $error("full byte word carries wrong flags");

    a_no_accept_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && r_out_valid && i_out_stall) |=> r_skid_valid)
        else $error("skid entry lost while output stalled");

endmodule

/* rtl/core/fasta_nucleotide_packer_top.sv */
// Top level of the FASTA nucleotide packer: ports, configuration registers, datapath.
//
//  Channel | Direction | Handshake             | Word
//  --------+-----------+-----------------------+-----------------------------------------
//  in      | input     | i_in_valid/o_in_stall | i_action, i_text_char
//  out     | output    | o_out_valid/i_out_stall | o_packed_byte, o_byte_valid,
//          |           |                       | o_empty_slots, o_stream_done
//  cfg     | input     | i_cfg_valid/o_cfg_ready | i_cfg_index, i_cfg_wdata
//
// One input word is taken per cycle while o_in_stall is low; the packing state updates on
// the accepting edge, when any result word is registered into the output or skid entry.
// Reset (i_rst_n low, synchronous) clears the packing state, the output and skid
// valid flags, and restores the register defaults (C=1, G=2, T=3, no drop).
// A stalled output word holds in the output register; one more fits in the skid entry,
// and o_in_stall rises only while that entry is occupied. Config writes are always ready.
module fasta_nucleotide_packer_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // input word channel
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic                           i_action,
    input  logic [fnp_pkg::CHAR_W-1:0]     i_text_char,
    // result word channel
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [fnp_pkg::CHAR_W-1:0]     o_packed_byte,
    output logic                           o_byte_valid,
    output logic [fnp_pkg::COUNT_W-1:0]    o_empty_slots,
    output logic                           o_stream_done,
    // configuration write channel
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [fnp_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [fnp_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);
    import fnp_pkg::*;

    logic        r_drop_partial;
    t_codes      r_codes;
    logic        cfg_write;
    logic        accept;
    logic        full;
    t_char_class char_class;
    t_result     out_word;

    // Registers are plain flops; the port never pushes back.
    assign o_cfg_ready = 1'b1;
    assign cfg_write   = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drop_partial <= 1'b0;
            r_codes.code_c <= 2'd1;
            r_codes.code_g <= 2'd2;
            r_codes.code_t <= 2'd3;
        end else if (cfg_write) begin
            case (i_cfg_index)
                CFG_DROP_PARTIAL: r_drop_partial <= i_cfg_wdata[0];
                CFG_CODE_C:       r_codes.code_c <= i_cfg_wdata;
                CFG_CODE_G:       r_codes.code_g <= i_cfg_wdata;
                CFG_CODE_T:       r_codes.code_t <= i_cfg_wdata;
                default:          r_drop_partial <= r_drop_partial;
            endcase
        end
    end

    // Stall only on a full skid entry, so a waiting result never blocks input.
    assign o_in_stall = full;
    assign accept     = i_in_valid && !o_in_stall;

    fnp_classify u_classify (
        .i_char  (i_text_char),
        .i_codes (r_codes),
        .o_class (char_class)
    );

    fnp_pack u_pack (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_action       (i_action),
        .i_class        (char_class),
        .i_drop_partial (r_drop_partial),
        .o_full         (full),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_out          (out_word)
    );

    assign o_packed_byte = out_word.packed_byte;
    assign o_byte_valid  = out_word.byte_valid;
    assign o_empty_slots = out_word.empty_slots;
    assign o_stream_done = out_word.stream_done;

endmodule
